### src/iadj_pkg.sv
// Shared types and constants for the 3x3 adjugate inverse pipeline.
package iadj_pkg;

    localparam int N_ELEM   = 9;
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 32;
    localparam int MAG_W    = 31;
    localparam int DET_W    = 48;
    localparam int DSUM_W   = 50;
    localparam int QUO_W    = 32;
    localparam int LOW_W    = 4;
    localparam int DIV_STEPS = 32;
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 336;
    localparam int M_USER_W = 2;

    // tuser bit positions on the result side
    localparam int USER_SINGULAR = 0;
    localparam int USER_OVERFLOW = 1;

    localparam logic [QUO_W-1:0] Q_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [QUO_W-1:0] Q_NEG_MAX = 32'h8000_0000;

    // Each cofactor is a*b - c*d; these name the element indexes of a, b, c, d.
    localparam int CA [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int CB [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int CC [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int CD [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
    // Cofactors paired with the first row for the determinant.
    localparam int DET_COF [3] = '{0, 3, 6};

    typedef struct packed {
        logic [N_ELEM-1:0][DET_W-1:0] rem;
        logic [N_ELEM-1:0][QUO_W-1:0] quo;
        logic [N_ELEM-1:0][LOW_W-1:0] low;
        logic [N_ELEM-1:0]            neg;
        logic [N_ELEM-1:0]            big;
        logic [DET_W-1:0]             den;
        logic [DET_W-1:0]             det;
        logic                         sing;
    } div_word_t;

endpackage

### src/iadj_front.sv
// Cofactor, determinant and divider set-up stages (six register stages).
module iadj_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [iadj_pkg::S_DATA_W-1:0] in_data,
    output logic                          out_valid,
    output iadj_pkg::div_word_t           out_word
);
    import iadj_pkg::*;

    logic signed [ELEM_W-1:0] a [N_ELEM];
    logic signed [PROD_W-1:0] pl_reg [N_ELEM];
    logic signed [PROD_W-1:0] pr_reg [N_ELEM];
    logic signed [ELEM_W-1:0] r1_reg [3];
    logic signed [ELEM_W-1:0] r2_reg [3];
    logic signed [PROD_W-1:0] adj_reg [N_ELEM];
    logic signed [DET_W-1:0]  dp_reg [3];
    logic [MAG_W-1:0]         m3_reg [N_ELEM];
    logic [MAG_W-1:0]         m4_reg [N_ELEM];
    logic [MAG_W-1:0]         m5_reg [N_ELEM];
    logic [N_ELEM-1:0]        n3_reg, n4_reg, n5_reg;
    logic signed [DSUM_W-1:0] dsum_reg;
    logic [DET_W-1:0]         den_reg;
    logic [DET_W-1:0]         det5_reg;
    logic                     dneg_reg;
    logic                     sing_reg;
    div_word_t                word_next, word_reg;
    logic [5:0]               v_reg;

    always_comb begin
        for (int k = 0; k < N_ELEM; k++) begin
            a[k] = in_data[k*ELEM_W +: ELEM_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Stage 1: the eighteen 2x2 products.
            for (int k = 0; k < N_ELEM; k++) begin
                pl_reg[k] <= a[CA[k]] * a[CB[k]];
                pr_reg[k] <= a[CC[k]] * a[CD[k]];
            end
            for (int j = 0; j < 3; j++) begin
                r1_reg[j] <= a[j];
                r2_reg[j] <= r1_reg[j];
            end
            // Stage 2: cofactors; each fits 32 bits signed.
            for (int k = 0; k < N_ELEM; k++) begin
                adj_reg[k] <= pl_reg[k] - pr_reg[k];
            end
            // Stage 3: first-row products and cofactor magnitudes.
            for (int j = 0; j < 3; j++) begin
                dp_reg[j] <= r2_reg[j] * adj_reg[DET_COF[j]];
            end
            for (int k = 0; k < N_ELEM; k++) begin
                n3_reg[k] <= adj_reg[k][PROD_W-1];
                m3_reg[k] <= adj_reg[k][PROD_W-1] ? MAG_W'(-adj_reg[k])
                                                   : MAG_W'(adj_reg[k]);
            end
            // Stage 4: determinant sum.
            dsum_reg <= DSUM_W'(dp_reg[0]) + DSUM_W'(dp_reg[1]) + DSUM_W'(dp_reg[2]);
            m4_reg   <= m3_reg;
            n4_reg   <= n3_reg;
            // Stage 5: determinant magnitude becomes the divisor.
            dneg_reg <= dsum_reg[DSUM_W-1];
            den_reg  <= dsum_reg[DSUM_W-1] ? DET_W'(-dsum_reg) : DET_W'(dsum_reg);
            det5_reg <= DET_W'(dsum_reg);
            sing_reg <= (dsum_reg == '0);
            m5_reg   <= m4_reg;
            n5_reg   <= n4_reg;
            // Stage 6: divider set-up.
            word_reg <= word_next;
        end
    end

    // The numerator is |cof| << 28. Its bits above 31 preload the remainder;
    // its four low magnitude bits feed the top four divide steps.
    always_comb begin
        word_next      = '0;
        word_next.den  = den_reg;
        word_next.det  = det5_reg;
        word_next.sing = sing_reg;
        for (int k = 0; k < N_ELEM; k++) begin
            word_next.rem[k] = DET_W'(m5_reg[k][MAG_W-1:LOW_W]);
            word_next.low[k] = m5_reg[k][LOW_W-1:0];
            word_next.neg[k] = n5_reg[k] ^ dneg_reg;
            word_next.big[k] = ({21'd0, m5_reg[k]} >= {den_reg, 4'd0});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    assign out_valid = v_reg[5];
    assign out_word  = word_reg;

endmodule

### src/iadj_div_stage.sv
// One restoring-division step for all nine lanes, registered.
module iadj_div_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  iadj_pkg::div_word_t in_word,
    output logic                out_valid,
    output iadj_pkg::div_word_t out_word
);
    import iadj_pkg::*;

    div_word_t          word_next, word_reg;
    logic               valid_reg;
    logic [DET_W:0]     trial;
    logic [DET_W:0]     diff;

    always_comb begin
        word_next = in_word;
        trial     = '0;
        diff      = '0;
        for (int k = 0; k < N_ELEM; k++) begin
            trial = {in_word.rem[k], in_word.low[k][LOW_W-1]};
            diff  = trial - {1'b0, in_word.den};
            word_next.low[k] = {in_word.low[k][LOW_W-2:0], 1'b0};
            if (!diff[DET_W]) begin
                word_next.rem[k] = diff[DET_W-1:0];
                word_next.quo[k] = {in_word.quo[k][QUO_W-2:0], 1'b1};
            end else begin
                word_next.rem[k] = trial[DET_W-1:0];
                word_next.quo[k] = {in_word.quo[k][QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

### src/inverse_3x3_adjugate_unit.sv
// Top level: pipelined 3x3 matrix inverse by the adjugate method.
//
//  channel | direction | payload
//  s_axis  | in        | tdata: m00..m22, 16 bits each, signed Q4.12
//  m_axis  | out       | tdata: inv00..inv22 (Q16.16), det_value (Q12.36); tuser: flags
//
// One word is accepted every cycle while m_axis is not stalled; the pipeline has six set-up stages,
// 32 divide steps (one quotient bit each per lane) and the output register.
// aresetn clears only the valid bits; data registers are not reset.
// A stall on m_axis freezes every stage together, so s_axis_tready follows
// it in the same cycle and nothing is lost or repeated.
module inverse_3x3_adjugate_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
    input  logic [iadj_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // inv00..inv22 (32 bits each), det_value (48 bits)
    output logic [iadj_pkg::M_DATA_W-1:0] m_axis_tdata,
    // singular, overflow
    output logic [iadj_pkg::M_USER_W-1:0] m_axis_tuser
);
    import iadj_pkg::*;

    logic                      en;
    logic                      dv [DIV_STEPS+1];
    div_word_t                 dw [DIV_STEPS+1];
    logic                      m_valid_reg;
    logic [M_DATA_W-1:0]       m_data_reg, m_data_next;
    logic [M_USER_W-1:0]       m_user_reg, m_user_next;
    div_word_t                 fw;
    logic [QUO_W-1:0]          q;
    logic [QUO_W-1:0]          r;
    logic                      ovf;

    assign en            = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    iadj_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .in_data   (s_axis_tdata),
        .out_valid (dv[0]),
        .out_word  (dw[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        iadj_div_stage u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (dv[g]),
            .in_word   (dw[g]),
            .out_valid (dv[g+1]),
            .out_word  (dw[g+1])
        );
    end

    // Sign, saturation and the singular override.
    always_comb begin
        fw          = dw[DIV_STEPS];
        m_data_next = '0;
        ovf         = 1'b0;
        q           = '0;
        r           = '0;
        for (int k = 0; k < N_ELEM; k++) begin
            q = fw.quo[k];
            if (fw.neg[k]) begin
                if (fw.big[k] || q > Q_NEG_MAX) begin
                    r   = Q_NEG_MAX;
                    ovf = 1'b1;
                end else begin
                    r = -q;
                end
            end else begin
                if (fw.big[k] || q > Q_POS_MAX) begin
                    r   = Q_POS_MAX;
                    ovf = 1'b1;
                end else begin
                    r = q;
                end
            end
            m_data_next[k*QUO_W +: QUO_W] = fw.sing ? '0 : r;
        end
        m_data_next[N_ELEM*QUO_W +: DET_W] = fw.sing ? '0 : fw.det;
        m_user_next                = '0;
        m_user_next[USER_SINGULAR] = fw.sing;
        m_user_next[USER_OVERFLOW] = ovf && !fw.sing;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv[DIV_STEPS];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTH
    a_sing_no_ovf : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[USER_SINGULAR] |-> !m_axis_tuser[USER_OVERFLOW])
        else $error("overflow raised on a singular result");

    a_sing_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[USER_SINGULAR] |-> m_axis_tdata == '0)
        else $error("singular result carries nonzero data");

    a_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    a_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");
`endif

endmodule

### tb/sv/tb_inverse_3x3_adjugate_unit.sv
// Testbench for the pipelined 3x3 adjugate matrix inverse unit.
`timescale 1ns / 100ps

module tb_inverse_3x3_adjugate_unit;
    import iadj_pkg::*;

    localparam int LATENCY      = 39;
    localparam int WATCHDOG_MAX = 5000;

    typedef struct {
        logic [QUO_W-1:0] inv [N_ELEM];
        logic [DET_W-1:0] det;
        logic             singular;
        logic             overflow;
    } inverse_t;

    logic                aclk;
    logic                aresetn;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [M_USER_W-1:0] m_axis_tuser;

    inverse_t expected_inverses [$];
    int       error_count;
    int       matrices_sent;
    int       results_seen;
    int       singular_seen;
    int       overflow_seen;
    int       idle_cycles;
    bit       steady_sink;

    inverse_3x3_adjugate_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic logic signed [63:0] elem(input logic [S_DATA_W-1:0] word, input int k);
        return 64'(signed'(word[k*ELEM_W +: ELEM_W]));
    endfunction

    // Cofactor over Q8.24, divided by the Q12.36 determinant into Q16.16.
    function automatic logic [QUO_W-1:0] scaled_quotient(input logic signed [63:0] cof,
                                                         input logic signed [63:0] det,
                                                         inout logic ovf);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        num = (cof < 0 ? -cof : cof) << 28;
        den = det < 0 ? -det : det;
        q   = num / den;
        if ((cof < 0) != (det < 0)) begin
            if (q > 64'h8000_0000) begin
                ovf = 1'b1;
                q   = 64'h8000_0000;
            end
            return QUO_W'(-q);
        end
        if (q > 64'h7FFF_FFFF) begin
            ovf = 1'b1;
            q   = 64'h7FFF_FFFF;
        end
        return QUO_W'(q);
    endfunction

    function automatic inverse_t invert_matrix(input logic [S_DATA_W-1:0] word);
        inverse_t r;
        logic signed [63:0] a [N_ELEM];
        logic signed [63:0] adj [N_ELEM];
        logic signed [63:0] det;
        logic ovf;
        for (int k = 0; k < N_ELEM; k++) a[k] = elem(word, k);
        adj[0] = a[4]*a[8] - a[5]*a[7];
        adj[1] = a[2]*a[7] - a[1]*a[8];
        adj[2] = a[1]*a[5] - a[2]*a[4];
        adj[3] = a[5]*a[6] - a[3]*a[8];
        adj[4] = a[0]*a[8] - a[2]*a[6];
        adj[5] = a[2]*a[3] - a[0]*a[5];
        adj[6] = a[3]*a[7] - a[4]*a[6];
        adj[7] = a[1]*a[6] - a[0]*a[7];
        adj[8] = a[0]*a[4] - a[1]*a[3];
        det = a[0]*adj[0] + a[1]*adj[3] + a[2]*adj[6];
        ovf = 1'b0;
        for (int k = 0; k < N_ELEM; k++) begin
            r.inv[k] = (det == 0) ? '0 : scaled_quotient(adj[k], det, ovf);
        end
        r.det      = DET_W'(det);
        r.singular = (det == 0);
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic [S_DATA_W-1:0] pack_matrix(input int e [N_ELEM]);
        logic [S_DATA_W-1:0] w;
        for (int k = 0; k < N_ELEM; k++) w[k*ELEM_W +: ELEM_W] = ELEM_W'(e[k]);
        return w;
    endfunction

    task automatic send_matrix(input logic [S_DATA_W-1:0] word, input bit allow_gaps);
        while (allow_gaps && $urandom_range(99) < 11) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        expected_inverses.push_back(invert_matrix(word));
        matrices_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_inverses.size() != 0) @(posedge aclk);
    endtask

    task automatic send_elements(input int e [N_ELEM]);
        send_matrix(pack_matrix(e), 1'b1);
    endtask

    task automatic test_directed();
        send_elements('{4096, 0, 0, 0, 4096, 0, 0, 0, 4096});
        send_elements('{-4096, 0, 0, 0, 4096, 0, 0, 0, -4096});
        send_elements('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_elements('{4096, 8192, 12288, 4096, 8192, 12288, 1, 2, 3});
        send_elements('{-32768, -32768, -32768, -32768, -32768, -32768,
                        -32768, -32768, -32768});
        send_elements('{32767, 0, 0, 0, 32767, 0, 0, 0, 32767});
        send_elements('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768});
        // Tiny diagonal entries give large inverses that still fit Q16.16.
        send_elements('{1, 0, 0, 0, 1, 0, 0, 0, 1});
        send_elements('{-1, 0, 0, 0, 1, 0, 0, 0, 1});
        send_elements('{1, 0, 0, 0, 1, 0, 0, 0, -1});
        // Inverse element of exactly -2^31 fits without overflow.
        send_elements('{1, 8, 0, 0, 1, 0, 0, 0, 1});
        // The opposite sign, or slightly larger off-diagonal terms, saturate and raise overflow.
        send_elements('{1, -8, 0, 0, 1, 0, 0, 0, 1});
        send_elements('{1, 9, 0, 0, 1, 0, 0, 0, 1});
        send_elements('{1, -9, 0, 0, 1, 0, 0, 0, 1});
        send_elements('{-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768});
        send_elements('{32767, -32768, 32767, -32768, 32767, -32768, 1, -1, 0});
        send_elements('{2, 3, 5, 7, 11, 13, 17, 19, 23});
        send_elements('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
        send_elements('{0, 4096, 0, 0, 0, 4096, 4096, 0, 0});
        send_elements('{0, 0, 4096, 0, 4096, 0, 4096, 0, 0});
        drain_results();
    endtask

    function automatic int random_element(input int mode);
        case (mode)
            0:       return $urandom_range(65535) - 32768;
            1:       return $urandom_range(8191) - 4096;
            2:       return $urandom_range(7) - 4;
            default: return ($urandom_range(1) != 0) ? 32767 : -32768;
        endcase
    endfunction

    task automatic test_random(input int count, input bit allow_gaps);
        int e [N_ELEM];
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(3);
            for (int k = 0; k < N_ELEM; k++) begin
                e[k] = ($urandom_range(9) == 0) ? random_element(3) : random_element(mode);
            end
            // Now and then make one row a copy of another for a singular input.
            if ($urandom_range(9) == 0) begin
                for (int k = 0; k < 3; k++) e[6 + k] = e[k];
            end
            send_matrix(pack_matrix(e), allow_gaps);
        end
    endtask

    task automatic test_pause_until_empty();
        test_random(20, 1'b1);
        drain_results();
        test_random(20, 1'b1);
        drain_results();
    endtask

    task automatic test_back_to_back();
        steady_sink = 1'b1;
        test_random(80, 1'b0);
        drain_results();
        steady_sink = 1'b0;
    endtask

    // Result checker and random sink stall.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_inverses.size() == 0) begin
                    $display("%0t: unexpected result word %h", $time, m_axis_tdata);
                    error_count++;
                end else begin
                    inverse_t want;
                    want = expected_inverses.pop_front();
                    results_seen++;
                    if (want.singular) singular_seen++;
                    if (want.overflow) overflow_seen++;
                    for (int k = 0; k < N_ELEM; k++) begin
                        if (m_axis_tdata[k*QUO_W +: QUO_W] !== want.inv[k]) begin
                            $display("%0t: inv%0d%0d expected %h actual %h", $time, k / 3,
                                     k % 3, want.inv[k], m_axis_tdata[k*QUO_W +: QUO_W]);
                            error_count++;
                        end
                    end
                    if (m_axis_tdata[N_ELEM*QUO_W +: DET_W] !== want.det) begin
                        $display("%0t: det_value expected %h actual %h", $time, want.det,
                                 m_axis_tdata[N_ELEM*QUO_W +: DET_W]);
                        error_count++;
                    end
                    if (m_axis_tuser[USER_SINGULAR] !== want.singular) begin
                        $display("%0t: singular expected %b actual %b", $time, want.singular,
                                 m_axis_tuser[USER_SINGULAR]);
                        error_count++;
                    end
                    if (m_axis_tuser[USER_OVERFLOW] !== want.overflow) begin
                        $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                                 m_axis_tuser[USER_OVERFLOW]);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= steady_sink || ($urandom_range(99) >= 11);
        end
    end

    // Watchdog on cycles where no word moves on either side.
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_MAX) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        error_count   = 0;
        matrices_sent = 0;
        results_seen  = 0;
        singular_seen = 0;
        overflow_seen = 0;
        steady_sink   = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(290, 1'b1);
        test_pause_until_empty();
        test_back_to_back();

        drain_results();
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Sent %0d matrices, checked %0d inverses (%0d singular, %0d saturated).",
                 matrices_sent, results_seen, singular_seen, overflow_seen);
        if (error_count == 0 && expected_inverses.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
